@@ rtl/fplm_pkg.sv @@
package fplm_pkg;

    // field widths
    localparam int GRP_W   = 4;
    localparam int PRICE_W = 32;
    localparam int VOL_W   = 24;
    localparam int FEE_W   = 32;
    localparam int UCOST_W = 48;
    localparam int PNL_W   = 48;
    localparam int MCOST_W = 48;
    localparam int HQTY_W  = 29;
    localparam int HCOST_W = 56;

    // internal widths
    localparam int HALF_W  = 24;
    localparam int LOT_W   = UCOST_W + VOL_W;
    localparam int PROD_W  = UCOST_W + VOL_W;
    localparam int DIV_W   = 56;

    // saturation limits
    localparam logic [UCOST_W-1:0]      UCOST_MAX = '1;
    localparam logic [MCOST_W-1:0]      MCOST_MAX = '1;
    localparam logic [HQTY_W-1:0]       HQTY_MAX  = '1;
    localparam logic [HCOST_W-1:0]      HCOST_MAX = '1;
    localparam logic signed [PNL_W-1:0] PNL_MAX   = {1'b0, {(PNL_W-1){1'b1}}};
    localparam logic signed [PNL_W-1:0] PNL_MIN   = {1'b1, {(PNL_W-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_B_DIV,
        ST_B_MUL1,
        ST_B_MUL2,
        ST_B_ACC,
        ST_S_CHECK,
        ST_S_MUL1,
        ST_S_MUL2,
        ST_S_ACC,
        ST_F_MUL1,
        ST_F_MUL2,
        ST_F_DIV,
        ST_F_WAIT,
        ST_P_MUL1,
        ST_P_MUL2,
        ST_DONE
    } fplm_state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_CPS_VOL,
        MUL_LOT_TAKE,
        MUL_FEES_M,
        MUL_PRICE_M
    } mul_sel_t;

    typedef enum logic {
        DIV_BUY,
        DIV_FEE
    } div_sel_t;

    typedef struct packed {
        logic     latch;
        logic     cps_load;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     buy_commit;
        logic     lot_read;
        logic     sell_commit;
        logic     out_load;
    } fplm_cmd_t;

    typedef struct packed {
        logic is_sell;
        logic full;
        logic vol_zero;
        logic walk_done;
        logic matched;
        logic div_done;
        logic out_free;
    } fplm_stat_t;

endpackage

@@ rtl/fifo_lot_pnl_matcher_core.sv @@
// channel  signals                                           accepted when
// in       in_valid, in_stall, group_index .. fees            in_valid && !in_stall
// out      out_valid, out_stall, matched .. lot_overflow      out_valid && !out_stall
//
// one trade at a time; a buy spreads its fees over the volume with the serial divider
// (one quotient bit a cycle), skipped when the volume is zero or the group is full
// a sell walks the head lots through the lot memory (one write, one registered read)
// and the multiplier (two half products, then their sum), then prorates matched fees
// reset clears all queues at once; the lot memory itself is not cleared
// a finished item sits in the output register while the next trade is taken
module fifo_lot_pnl_matcher_core #(
    parameter int GROUPS         = 16,
    parameter int LOTS_PER_GROUP = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fplm_pkg::GRP_W-1:0]          group_index,
    input  logic                                is_sell,
    input  logic [fplm_pkg::PRICE_W-1:0]        price,
    input  logic [fplm_pkg::VOL_W-1:0]          volume,
    input  logic [fplm_pkg::FEE_W-1:0]          fees,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                matched,
    output logic signed [fplm_pkg::PNL_W-1:0]   realized_pnl,
    output logic [fplm_pkg::MCOST_W-1:0]        matched_cost,
    output logic [fplm_pkg::VOL_W-1:0]          unmatched_volume,
    output logic [fplm_pkg::HQTY_W-1:0]         held_quantity,
    output logic [fplm_pkg::HCOST_W-1:0]        held_cost,
    output logic                                lot_overflow
);
    import fplm_pkg::*;

    fplm_cmd_t  cmd;
    fplm_stat_t stat;

    // sequencer
    fplm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // lot queues, arithmetic and output register
    fplm_dp #(
        .GROUPS         (GROUPS),
        .LOTS_PER_GROUP (LOTS_PER_GROUP),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .group_index      (group_index),
        .is_sell          (is_sell),
        .price            (price),
        .volume           (volume),
        .fees             (fees),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .realized_pnl     (realized_pnl),
        .matched_cost     (matched_cost),
        .unmatched_volume (unmatched_volume),
        .held_quantity    (held_quantity),
        .held_cost        (held_cost),
        .lot_overflow     (lot_overflow)
    );

endmodule

@@ rtl/fplm_div.sv @@
module fplm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fplm_pkg::DIV_W-1:0] dividend,
    input  logic [fplm_pkg::VOL_W-1:0] divisor,
    output logic [fplm_pkg::DIV_W-1:0] quotient,
    output logic                       done
);
    import fplm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] quo_reg;
    logic [VOL_W:0]   rem_reg;
    logic [VOL_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [VOL_W:0]   rem_shift;
    logic             fits;
    logic [VOL_W:0]   rem_next;
    logic [DIV_W-1:0] quo_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_shift = {rem_reg[VOL_W-1:0], quo_reg[DIV_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_next  = fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
        quo_next  = {quo_reg[DIV_W-2:0], fits};
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ rtl/fplm_dp.sv @@
module fplm_dp #(
    parameter int GROUPS         = 16,
    parameter int LOTS_PER_GROUP = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fplm_pkg::fplm_cmd_t                 cmd,
    output fplm_pkg::fplm_stat_t                stat,
    input  logic [fplm_pkg::GRP_W-1:0]          group_index,
    input  logic                                is_sell,
    input  logic [fplm_pkg::PRICE_W-1:0]        price,
    input  logic [fplm_pkg::VOL_W-1:0]          volume,
    input  logic [fplm_pkg::FEE_W-1:0]          fees,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                matched,
    output logic signed [fplm_pkg::PNL_W-1:0]   realized_pnl,
    output logic [fplm_pkg::MCOST_W-1:0]        matched_cost,
    output logic [fplm_pkg::VOL_W-1:0]          unmatched_volume,
    output logic [fplm_pkg::HQTY_W-1:0]         held_quantity,
    output logic [fplm_pkg::HCOST_W-1:0]        held_cost,
    output logic                                lot_overflow
);
    import fplm_pkg::*;

    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int HW    = (LOTS_PER_GROUP > 1) ? $clog2(LOTS_PER_GROUP) : 1;
    localparam int CW    = $clog2(LOTS_PER_GROUP + 1);
    localparam int OW    = $clog2(2 * LOTS_PER_GROUP);
    localparam int DEPTH = GROUPS * LOTS_PER_GROUP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = VOL_W + CW;
    localparam int QXW   = (QW > HQTY_W) ? QW : HQTY_W;
    localparam int SW    = PROD_W + CW;
    localparam int CFW   = PROD_W - FRACTION_BITS;
    localparam int PW    = PROD_W + 2;
    localparam int CSW   = DIV_W + 1;

    // group number folding, constant table
    logic [GW-1:0] grp_map [2**GRP_W];
    for (genvar i = 0; i < 2**GRP_W; i++)
    begin : g_map
        assign grp_map[i] = GW'(i % GROUPS);
    end

    // item registers
    logic [GW-1:0]      grp_reg;
    logic               sell_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic [FEE_W-1:0]   fees_reg;
    logic [VOL_W-1:0]   need_reg;
    logic [VOL_W-1:0]   m_reg;
    logic [PROD_W-1:0]  ms_reg;
    logic               matched_reg;
    logic               placed_reg;
    logic [UCOST_W-1:0] cps_reg;

    // per group state
    logic [CW-1:0] cnt_reg  [GROUPS];
    logic [HW-1:0] head_reg [GROUPS];
    logic [QW-1:0] qty_reg  [GROUPS];
    logic [SW-1:0] sum_reg  [GROUPS];

    logic [CW-1:0] cur_cnt;
    logic [HW-1:0] cur_head;
    logic [QW-1:0] cur_qty;
    logic [SW-1:0] cur_sum;
    logic [HW-1:0] head_inc;
    logic [OW-1:0] tail_sum;
    logic [HW-1:0] tail_slot;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] head_addr;
    logic [AW-1:0] tail_addr;

    // lot memory
    logic [LOT_W-1:0]   lot_mem [DEPTH];
    logic [LOT_W-1:0]   rd_reg;
    logic [UCOST_W-1:0] rd_cost;
    logic [VOL_W-1:0]   rd_vol;
    logic [VOL_W-1:0]   take;
    logic [VOL_W-1:0]   lv_new;
    logic               pop;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [LOT_W-1:0]   mem_wdata;

    // multiplier
    logic [UCOST_W-1:0]      mul_a;
    logic [VOL_W-1:0]        mul_b;
    logic [2*HALF_W-1:0]     part_lo_reg;
    logic [2*HALF_W-1:0]     part_hi_reg;
    logic                    mul_pend_reg;
    logic [PROD_W-1:0]       product_reg;

    // divider
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] quot;
    logic             div_done;
    logic [CSW-1:0]   cps_sum;

    // result shaping
    logic [QXW-1:0]           qty_x;
    logic [SW-1:0]            cost_s;
    logic [CFW-1:0]           c_full;
    logic signed [PW-1:0]     pnl_w;
    logic signed [PNL_W-1:0]  pnl_sat;
    logic [MCOST_W-1:0]       mcost_sat;
    logic [HQTY_W-1:0]        hq_sat;
    logic [HCOST_W-1:0]       hc_sat;

    logic                     out_valid_reg;
    logic                     matched_o_reg;
    logic signed [PNL_W-1:0]  pnl_o_reg;
    logic [MCOST_W-1:0]       mcost_o_reg;
    logic [VOL_W-1:0]         unm_o_reg;
    logic [HQTY_W-1:0]        hq_o_reg;
    logic [HCOST_W-1:0]       hc_o_reg;
    logic                     ovf_o_reg;

    // queue addressing
    always_comb
    begin
        cur_cnt   = cnt_reg[grp_reg];
        cur_head  = head_reg[grp_reg];
        cur_qty   = qty_reg[grp_reg];
        cur_sum   = sum_reg[grp_reg];
        head_inc  = (cur_head == HW'(LOTS_PER_GROUP - 1)) ? '0 : cur_head + 1'b1;
        tail_sum  = OW'(cur_head) + OW'(cur_cnt);
        tail_slot = (tail_sum >= OW'(LOTS_PER_GROUP)) ?
                    HW'(tail_sum - OW'(LOTS_PER_GROUP)) : HW'(tail_sum);
        base_addr = AW'(grp_reg) * AW'(LOTS_PER_GROUP);
        head_addr = base_addr + AW'(cur_head);
        tail_addr = base_addr + AW'(tail_slot);
    end

    // head lot consumption
    always_comb
    begin
        rd_cost = rd_reg[LOT_W-1:VOL_W];
        rd_vol  = rd_reg[VOL_W-1:0];
        take    = (rd_vol < need_reg) ? rd_vol : need_reg;
        lv_new  = rd_vol - take;
        pop     = (lv_new == '0);
    end

    // item capture, sell accumulation and unit cost load
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            grp_reg     <= grp_map[group_index];
            sell_reg    <= is_sell;
            price_reg   <= price;
            vol_reg     <= volume;
            fees_reg    <= fees;
            need_reg    <= volume;
            m_reg       <= '0;
            ms_reg      <= '0;
            matched_reg <= 1'b0;
            placed_reg  <= 1'b0;
        end
        else if (cmd.sell_commit)
        begin
            need_reg    <= need_reg - take;
            m_reg       <= m_reg + take;
            ms_reg      <= ms_reg + product_reg;
            matched_reg <= 1'b1;
        end
        // buy lot went into its queue
        if (cmd.buy_commit)
            placed_reg <= 1'b1;
        if (cmd.cps_load)
            cps_reg <= (cps_sum > CSW'(UCOST_MAX)) ? UCOST_MAX : cps_sum[UCOST_W-1:0];
    end

    // unit cost with fee spread over the volume
    assign cps_sum = (CSW'(price_reg) << FRACTION_BITS)
                   + ((vol_reg == '0) ? '0 : CSW'(quot));

    // group counters and exact cost sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
                qty_reg[i]  <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.buy_commit)
            begin
                cnt_reg[grp_reg] <= cur_cnt + 1'b1;
                qty_reg[grp_reg] <= cur_qty + QW'(vol_reg);
                sum_reg[grp_reg] <= cur_sum + SW'(product_reg);
            end
            if (cmd.sell_commit)
            begin
                qty_reg[grp_reg] <= cur_qty - QW'(take);
                sum_reg[grp_reg] <= cur_sum - SW'(product_reg);
                if (pop)
                begin
                    head_reg[grp_reg] <= head_inc;
                    cnt_reg[grp_reg]  <= cur_cnt - 1'b1;
                end
            end
        end
    end

    // lot memory, one write and one registered read
    always_comb
    begin
        mem_we    = cmd.buy_commit || (cmd.sell_commit && !pop);
        mem_waddr = cmd.buy_commit ? tail_addr : head_addr;
        mem_wdata = cmd.buy_commit ? {cps_reg, vol_reg} : {rd_cost, lv_new};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            lot_mem[mem_waddr] <= mem_wdata;
        if (cmd.lot_read)
            rd_reg <= lot_mem[head_addr];
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_CPS_VOL:
            begin
                mul_a = cps_reg;
                mul_b = vol_reg;
            end
            MUL_LOT_TAKE:
            begin
                mul_a = rd_cost;
                mul_b = take;
            end
            MUL_FEES_M:
            begin
                mul_a = UCOST_W'(fees_reg);
                mul_b = m_reg;
            end
            MUL_PRICE_M:
            begin
                mul_a = UCOST_W'(price_reg);
                mul_b = m_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // two half products, then their sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_pend_reg <= 1'b0;
        else
            mul_pend_reg <= (cmd.mul_sel != MUL_NONE);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != MUL_NONE)
        begin
            part_lo_reg <= mul_a[HALF_W-1:0] * mul_b;
            part_hi_reg <= mul_a[UCOST_W-1:HALF_W] * mul_b;
        end
        if (mul_pend_reg)
            product_reg <= {part_hi_reg, {HALF_W{1'b0}}} + PROD_W'(part_lo_reg);
    end

    // serial divider for fee spread and fee proration
    assign div_dividend = (cmd.div_sel == DIV_BUY) ?
                          (DIV_W'(fees_reg) << FRACTION_BITS) : product_reg[DIV_W-1:0];

    fplm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (vol_reg),
        .quotient (quot),
        .done     (div_done)
    );

    // saturated result fields
    always_comb
    begin
        qty_x     = QXW'(cur_qty);
        hq_sat    = (qty_x > QXW'(HQTY_MAX)) ? HQTY_MAX : qty_x[HQTY_W-1:0];
        cost_s    = cur_sum >> FRACTION_BITS;
        hc_sat    = (cost_s > SW'(HCOST_MAX)) ? HCOST_MAX : cost_s[HCOST_W-1:0];
        c_full    = CFW'(ms_reg >> FRACTION_BITS);
        mcost_sat = (c_full > CFW'(MCOST_MAX)) ? MCOST_MAX : c_full[MCOST_W-1:0];
        pnl_w     = $signed(PW'(product_reg)) - $signed(PW'(c_full)) - $signed(PW'(quot));
        if (pnl_w > PW'(PNL_MAX))
            pnl_sat = PNL_MAX;
        else if (pnl_w < PW'(PNL_MIN))
            pnl_sat = PNL_MIN;
        else
            pnl_sat = pnl_w[PNL_W-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hq_o_reg <= hq_sat;
            hc_o_reg <= hc_sat;
            if (sell_reg)
            begin
                matched_o_reg <= matched_reg;
                pnl_o_reg     <= matched_reg ? pnl_sat : '0;
                mcost_o_reg   <= matched_reg ? mcost_sat : '0;
                unm_o_reg     <= need_reg;
                ovf_o_reg     <= 1'b0;
            end
            else
            begin
                matched_o_reg <= 1'b0;
                pnl_o_reg     <= '0;
                mcost_o_reg   <= '0;
                unm_o_reg     <= '0;
                ovf_o_reg     <= !placed_reg;
            end
        end
    end

    // status to the controller
    always_comb
    begin
        stat.is_sell   = sell_reg;
        stat.full      = (cur_cnt == CW'(LOTS_PER_GROUP));
        stat.vol_zero  = (vol_reg == '0);
        stat.walk_done = (need_reg == '0) || (cur_cnt == '0);
        stat.matched   = matched_reg;
        stat.div_done  = div_done;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_o_reg;
    assign realized_pnl     = pnl_o_reg;
    assign matched_cost     = mcost_o_reg;
    assign unmatched_volume = unm_o_reg;
    assign held_quantity    = hq_o_reg;
    assign held_cost        = hc_o_reg;
    assign lot_overflow     = ovf_o_reg;

endmodule

@@ rtl/fplm_ctrl.sv @@
module fplm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fplm_pkg::fplm_stat_t stat,
    output fplm_pkg::fplm_cmd_t  cmd
);
    import fplm_pkg::*;

    fplm_state_t state_reg;
    fplm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
                if (stat.is_sell)
                    state_next = ST_S_CHECK;
                else if (stat.full)
                    state_next = ST_DONE;
                else if (stat.vol_zero)
                    state_next = ST_B_MUL1;
                else
                    state_next = ST_B_DIV;
            ST_B_DIV:
                if (stat.div_done)
                    state_next = ST_B_MUL1;
            ST_B_MUL1:  state_next = ST_B_MUL2;
            ST_B_MUL2:  state_next = ST_B_ACC;
            ST_B_ACC:   state_next = ST_DONE;
            ST_S_CHECK:
                if (!stat.walk_done)
                    state_next = ST_S_MUL1;
                else if (stat.matched)
                    state_next = ST_F_MUL1;
                else
                    state_next = ST_DONE;
            ST_S_MUL1:  state_next = ST_S_MUL2;
            ST_S_MUL2:  state_next = ST_S_ACC;
            ST_S_ACC:   state_next = ST_S_CHECK;
            ST_F_MUL1:  state_next = ST_F_MUL2;
            ST_F_MUL2:  state_next = ST_F_DIV;
            ST_F_DIV:   state_next = ST_F_WAIT;
            ST_F_WAIT:
                if (stat.div_done)
                    state_next = ST_P_MUL1;
            ST_P_MUL1:  state_next = ST_P_MUL2;
            ST_P_MUL2:  state_next = ST_DONE;
            ST_DONE:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
                cmd.latch = in_valid;
            ST_DISPATCH:
                if (!stat.is_sell && !stat.full)
                begin
                    cmd.cps_load  = stat.vol_zero;
                    cmd.div_start = !stat.vol_zero;
                    cmd.div_sel   = DIV_BUY;
                end
            ST_B_DIV:
                cmd.cps_load = stat.div_done;
            ST_B_MUL1:
                cmd.mul_sel = MUL_CPS_VOL;
            ST_B_ACC:
                cmd.buy_commit = 1'b1;
            ST_S_CHECK:
                cmd.lot_read = !stat.walk_done;
            ST_S_MUL1:
                cmd.mul_sel = MUL_LOT_TAKE;
            ST_S_ACC:
                cmd.sell_commit = 1'b1;
            ST_F_MUL1:
                cmd.mul_sel = MUL_FEES_M;
            ST_F_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_FEE;
            end
            ST_P_MUL1:
                cmd.mul_sel = MUL_PRICE_M;
            ST_DONE:
                cmd.out_load = stat.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

@@ rtl/fplm_chk.sv @@
module fplm_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              matched,
    input logic signed [fplm_pkg::PNL_W-1:0] realized_pnl,
    input logic [fplm_pkg::MCOST_W-1:0]      matched_cost,
    input logic [fplm_pkg::VOL_W-1:0]        unmatched_volume,
    input logic                              lot_overflow
);
    import fplm_pkg::*;

    // a stalled item stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("item dropped while stalled");

    // a stalled item keeps its values
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(realized_pnl) && $stable(matched_cost))
        else $error("stalled item changed");

    // a trade cannot both match and overflow
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(matched && lot_overflow))
        else $error("matched and overflow together");

    // nothing matched means no pnl and no cost
    a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> realized_pnl == '0 && matched_cost == '0)
        else $error("pnl without a match");

    // a dropped buy reports no leftover sell volume
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lot_overflow |-> unmatched_volume == '0)
        else $error("overflow with unmatched volume");

endmodule

bind fifo_lot_pnl_matcher_core fplm_chk u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .matched          (matched),
    .realized_pnl     (realized_pnl),
    .matched_cost     (matched_cost),
    .unmatched_volume (unmatched_volume),
    .lot_overflow     (lot_overflow)
);
